[rtl/core/ppm_pkg.sv]
// Package: shared types, codes and constants of the PPM stream decoder.
`timescale 1ns / 1ps
package ppm_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_PIXEL   = 3'd1;
    localparam logic [2:0] KIND_OK      = 3'd2;
    localparam logic [2:0] KIND_HDR_ERR = 3'd3;
    localparam logic [2:0] KIND_PIX_ERR = 3'd4;

    localparam logic [1:0] FMT_P2 = 2'd0;
    localparam logic [1:0] FMT_P3 = 2'd1;
    localparam logic [1:0] FMT_P6 = 2'd2;

    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_2       = 8'h32;
    localparam logic [7:0] CH_3       = 8'h33;
    localparam logic [7:0] CH_6       = 8'h36;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [15:0] FULL_SCALE = 16'd255;

    // Work item handed from the parser to the back end
    typedef struct packed {
        logic [2:0]  kind;
        logic        scale;      // pixel needs sample*255/maxval
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        logic [12:0] width;
        logic [12:0] height;
        logic [15:0] maxval;
        logic [1:0]  fmt;
    } ppm_job_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
    } ppm_in_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] max_value;
        logic [1:0]  format_code;
    } ppm_out_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    // Accumulate one decimal digit, saturating at 65535
    function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [7:0] c);
        logic [20:0] r;
        r = {v, 3'b000} + {4'b0, v, 1'b0} + {13'b0, c - 8'd48};
        return (r > 21'd65535) ? 16'hFFFF : r[15:0];
    endfunction

endpackage

[rtl/core/ppm_stream_if.sv]
// Interface: valid/ready stream channel with a generic payload.
`timescale 1ns / 1ps
interface ppm_stream_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/ppm_parser.sv]
// Front end: parses header, P3 text and P6 raw pixels; emits one job per finished item.
`timescale 1ns / 1ps
module ppm_parser
    import ppm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ppm_in_t  in_beat,
    output logic     job_valid,
    input  logic     job_ready,
    output ppm_job_t job
);

    typedef enum logic [13:0] {
        PH_BEGIN   = 14'b00000000000001,
        PH_FORMAT  = 14'b00000000000010,
        PH_WIDTH   = 14'b00000000000100,
        PH_HEIGHT  = 14'b00000000001000,
        PH_DEPTH   = 14'b00000000010000,
        PH_TAIL    = 14'b00000000100000,
        PH_SKIP    = 14'b00000001000000,
        PH_COMMENT = 14'b00000010000000,
        PH_PSKIP   = 14'b00000100000000,
        PH_RED     = 14'b00001000000000,
        PH_GREEN   = 14'b00010000000000,
        PH_BLUE    = 14'b00100000000000,
        PH_RAW     = 14'b01000000000000,
        PH_HALT    = 14'b10000000000000
    } phase_t;

    phase_t      phase_reg, phase_next, resume_reg, resume_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [15:0] w_reg, w_next, h_reg, h_next, m_reg, m_next;
    logic [15:0] s0_reg, s0_next, s1_reg, s1_next, s2_reg, s2_next;
    logic [1:0]  ri_reg, ri_next;
    logic [11:0] col_reg, col_next, row_reg, row_next;
    logic [2:0]  err_reg, err_next;
    logic        done_reg, done_next;
    logic        hdr_reg, hdr_next;   // header complete
    logic        emit;
    ppm_job_t    jb;
    logic        take;

    // Accept a beat only when the queue can take whatever it produces
    assign in_ready  = job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = take && emit;
    assign job       = jb;

    always_comb
    begin
        logic [7:0]  c;
        phase_t      ph;
        logic        last;
        logic [12:0] col1, row1;
        c           = in_beat.data_byte;
        phase_next  = phase_reg;
        resume_next = resume_reg;
        fmt_next    = fmt_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        m_next      = m_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        ri_next     = ri_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        err_next    = err_reg;
        done_next   = done_reg;
        hdr_next    = hdr_reg;
        emit        = 1'b0;
        jb          = '0;
        col1        = {1'b0, col_reg} + 13'd1;
        row1        = {1'b0, row_reg} + 13'd1;
        last        = ({3'b0, col1} >= w_reg) && ({3'b0, row1} >= h_reg);
        ph          = phase_reg;
        // Resolve the zero-byte transitions (skip into a field, depth into tail) up front
        if (ph == PH_SKIP && !is_ws(c) && c != CH_HASH)
            ph = resume_reg;
        if (ph == PH_PSKIP && !is_ws(c))
            ph = resume_reg;
        if (ph == PH_DEPTH && !is_dig(c) && is_ws(c))
            ph = PH_TAIL;

        if (in_beat.cmd)
        begin
            // Report final status and return to reset state
            emit = 1'b1;
            if (err_reg != 3'd0)             jb.kind = err_reg;
            else if (!hdr_reg)               jb.kind = KIND_HDR_ERR;
            else if (fmt_reg == FMT_P6)      jb.kind = KIND_OK;
            else                             jb.kind = done_reg ? KIND_OK : KIND_PIX_ERR;
            phase_next  = PH_BEGIN;
            resume_next = PH_WIDTH;
            fmt_next    = FMT_P2;
            w_next = '0; h_next = '0; m_next = '0;
            s0_next = '0; s1_next = '0; s2_next = '0;
            ri_next = '0; col_next = '0; row_next = '0;
            err_next = '0; done_next = 1'b0; hdr_next = 1'b0;
        end
        else
        begin
            unique case (ph)
                PH_BEGIN:
                begin
                    if (c == CH_P) phase_next = PH_FORMAT;
                    else begin emit = 1'b1; jb.kind = KIND_HDR_ERR; end
                end
                PH_FORMAT:
                begin
                    phase_next  = PH_SKIP;
                    resume_next = PH_WIDTH;
                    if (c == CH_2)      fmt_next = FMT_P2;
                    else if (c == CH_3) fmt_next = FMT_P3;
                    else if (c == CH_6) fmt_next = FMT_P6;
                    else begin emit = 1'b1; jb.kind = KIND_HDR_ERR; end
                end
                PH_WIDTH, PH_HEIGHT:
                begin
                    if (is_dig(c))
                    begin
                        phase_next = ph;
                        if (ph == PH_WIDTH) w_next = acc_digit(w_reg, c);
                        else                h_next = acc_digit(h_reg, c);
                    end
                    else if (is_ws(c))
                    begin
                        phase_next  = PH_SKIP;
                        resume_next = (ph == PH_WIDTH) ? PH_HEIGHT : PH_DEPTH;
                    end
                    else begin emit = 1'b1; jb.kind = KIND_HDR_ERR; end
                end
                PH_DEPTH:
                begin
                    if (is_dig(c))
                    begin
                        phase_next = PH_DEPTH;
                        m_next = acc_digit(m_reg, c);
                    end
                    else begin emit = 1'b1; jb.kind = KIND_HDR_ERR; end
                end
                PH_TAIL:
                begin
                    phase_next = PH_TAIL;
                    if (c == CH_NEWLINE)
                    begin
                        emit = 1'b1;
                        if (w_reg == '0 || h_reg == '0 || m_reg == '0 ||
                            {1'b0, w_reg} > 17'(MAX_WIDTH) ||
                            {1'b0, h_reg} > 17'(MAX_HEIGHT) || fmt_reg == FMT_P2)
                            jb.kind = KIND_HDR_ERR;
                        else
                        begin
                            jb.kind   = KIND_HEADER;
                            jb.width  = w_reg[12:0];
                            jb.height = h_reg[12:0];
                            jb.maxval = m_reg;
                            jb.fmt    = fmt_reg;
                            hdr_next  = 1'b1;
                            col_next = '0; row_next = '0; ri_next = '0;
                            s0_next = '0; s1_next = '0; s2_next = '0;
                            if (fmt_reg == FMT_P3)
                            begin
                                phase_next  = PH_PSKIP;
                                resume_next = PH_RED;
                            end
                            else
                                phase_next = PH_RAW;
                        end
                    end
                    else if (!is_ws(c)) begin emit = 1'b1; jb.kind = KIND_HDR_ERR; end
                end
                PH_SKIP:
                begin
                    if (c == CH_HASH) phase_next = PH_COMMENT;
                end
                PH_COMMENT:
                begin
                    if (c == CH_NEWLINE) phase_next = PH_SKIP;
                end
                PH_PSKIP: ;
                PH_RED, PH_GREEN, PH_BLUE:
                begin
                    if (is_dig(c))
                    begin
                        phase_next = ph;
                        if (ph == PH_RED)        s0_next = acc_digit(s0_reg, c);
                        else if (ph == PH_GREEN) s1_next = acc_digit(s1_reg, c);
                        else                     s2_next = acc_digit(s2_reg, c);
                    end
                    else if (!is_ws(c)) begin emit = 1'b1; jb.kind = KIND_PIX_ERR; end
                    else if (ph != PH_BLUE)
                    begin
                        phase_next  = PH_PSKIP;
                        resume_next = (ph == PH_RED) ? PH_GREEN : PH_BLUE;
                    end
                    else
                    begin
                        phase_next  = PH_PSKIP;
                        resume_next = PH_RED;
                        emit     = 1'b1;
                        jb.kind  = KIND_PIXEL;
                        jb.scale = (m_reg != FULL_SCALE);
                        jb.r = s0_reg; jb.g = s1_reg; jb.b = s2_reg;
                        jb.maxval = m_reg;
                        s0_next = '0; s1_next = '0; s2_next = '0;
                    end
                end
                PH_RAW:
                begin
                    phase_next = PH_RAW;
                    if (ri_reg == 2'd0)      begin s0_next = {8'b0, c}; ri_next = 2'd1; end
                    else if (ri_reg == 2'd1) begin s1_next = {8'b0, c}; ri_next = 2'd2; end
                    else
                    begin
                        ri_next  = 2'd0;
                        emit     = 1'b1;
                        jb.kind  = KIND_PIXEL;
                        jb.r = s0_reg; jb.g = s1_reg; jb.b = {8'b0, c};
                    end
                end
                PH_HALT: ;
                default: ;
            endcase
            // Errors halt the parser
            if (emit && (jb.kind == KIND_HDR_ERR || jb.kind == KIND_PIX_ERR))
            begin
                err_next   = jb.kind;
                phase_next = PH_HALT;
            end
            // Place pixel and advance the raster position
            if (emit && jb.kind == KIND_PIXEL)
            begin
                jb.column = col_reg;
                jb.row    = row_reg;
                jb.last   = last;
                if (last)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_HALT;
                end
                else if ({3'b0, col1} >= w_reg)
                begin
                    col_next = '0;
                    row_next = row1[11:0];
                end
                else
                    col_next = col1[11:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BEGIN;
            resume_reg <= PH_WIDTH;
            fmt_reg    <= FMT_P2;
            w_reg <= '0; h_reg <= '0; m_reg <= '0;
            s0_reg <= '0; s1_reg <= '0; s2_reg <= '0;
            ri_reg <= '0; col_reg <= '0; row_reg <= '0;
            err_reg <= '0; done_reg <= 1'b0; hdr_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            fmt_reg    <= fmt_next;
            w_reg <= w_next; h_reg <= h_next; m_reg <= m_next;
            s0_reg <= s0_next; s1_reg <= s1_next; s2_reg <= s2_next;
            ri_reg <= ri_next; col_reg <= col_next; row_reg <= row_next;
            err_reg <= err_next; done_reg <= done_next; hdr_reg <= hdr_next;
        end
    end

    // A halted parser never emits pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && phase_reg == PH_HALT) |-> job.kind != KIND_PIXEL)
        else $error("pixel emitted after halt");
    // The raster position stays inside the header width
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job.kind == KIND_PIXEL) |-> ({4'b0, job.column} < w_reg))
        else $error("column beyond width");
    // End command always leaves the parser at its start
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_beat.cmd) |=> (phase_reg == PH_BEGIN && err_reg == 3'd0))
        else $error("end command did not reset parser");

endmodule

[rtl/core/ppm_job_fifo.sv]
// Queue: short register FIFO between parser and back end.
`timescale 1ns / 1ps
module ppm_job_fifo
    import ppm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  ppm_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output ppm_job_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ppm_job_t        mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr, rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Store a beat at the write pointer
    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("fifo overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !rd) else $error("fifo underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("fifo count slip");

endmodule

[rtl/core/ppm_scaler.sv]
// Back end: scales P3 samples by 255/maxval with a shared serial divider; other jobs pass through.
`timescale 1ns / 1ps
module ppm_scaler
    import ppm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  ppm_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output ppm_out_t out_beat
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } st_t;

    st_t         st_reg;
    ppm_job_t    job_reg;
    logic [1:0]  ch_reg;       // current component
    logic [4:0]  bit_reg;      // divider step
    logic [23:0] num_reg;      // dividend being shifted out
    logic [16:0] rem_reg;
    logic [7:0]  q_reg;        // low bits of quotient
    logic [7:0]  res_reg [3];
    logic [16:0] trial;
    logic [23:0] prod;
    logic [15:0] pick;

    assign job_ready = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    pick = job_reg.r;
            2'd1:    pick = job_reg.g;
            default: pick = job_reg.b;
        endcase
    end
    // sample*255 = sample*256 - sample
    assign prod  = {pick, 8'b0} - {8'b0, pick};
    assign trial = {rem_reg[15:0], num_reg[23]} - {1'b0, job_reg.maxval};

    // Run one restoring-division bit per cycle, component by component
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            ch_reg  <= '0;
            bit_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        ch_reg  <= '0;
                        bit_reg <= '0;
                        st_reg  <= (job.kind == KIND_PIXEL && job.scale) ? ST_DIV : ST_OUT;
                    end
                end
                ST_DIV:
                begin
                    if (bit_reg == 5'd24)
                    begin
                        bit_reg <= '0;
                        if (ch_reg == 2'd2) st_reg <= ST_OUT;
                        else ch_reg <= ch_reg + 2'd1;
                    end
                    else
                        bit_reg <= bit_reg + 5'd1;
                end
                ST_OUT:
                begin
                    if (out_ready) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && job_valid)
        begin
            job_reg    <= job;
            res_reg[0] <= job.r[7:0];
            res_reg[1] <= job.g[7:0];
            res_reg[2] <= job.b[7:0];
        end
        else if (st_reg == ST_DIV)
        begin
            if (bit_reg == 5'd0)
            begin
                num_reg <= prod;
                rem_reg <= '0;
                q_reg   <= '0;
            end
            else
            begin
                if (!trial[16])
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[15:0], num_reg[23]};
                    q_reg   <= {q_reg[6:0], 1'b0};
                end
                num_reg <= {num_reg[22:0], 1'b0};
                if (bit_reg == 5'd24)
                    res_reg[ch_reg] <= {q_reg[6:0], !trial[16]};
            end
        end
    end

    always_comb
    begin
        out_beat             = '0;
        out_beat.result_kind = job_reg.kind;
        if (job_reg.kind == KIND_PIXEL)
        begin
            out_beat.red        = res_reg[0];
            out_beat.green      = res_reg[1];
            out_beat.blue       = res_reg[2];
            out_beat.column     = job_reg.column;
            out_beat.row        = job_reg.row;
            out_beat.last_pixel = job_reg.last;
        end
        else if (job_reg.kind == KIND_HEADER)
        begin
            out_beat.image_width  = job_reg.width;
            out_beat.image_height = job_reg.height;
            out_beat.max_value    = job_reg.maxval;
            out_beat.format_code  = job_reg.fmt;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |-> (job_reg.maxval != 16'd0))
        else $error("divide by zero maxval");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |-> (ch_reg != 2'd3)) else $error("bad component");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

[rtl/core/ppm_stream_decoder_core.sv]
// PPM stream decoder: P3/P6 header and pixel decoder, one byte per beat.
// Path: a result is registered in the queue and then in the back end before it
// appears; a scaled P3 pixel (maxval other than 255) also waits on serial division.
// Throughput: one byte per cycle while the queue has room; the back end takes one
// result at a time, stalling during division; a 4-entry queue absorbs the difference.
// Reset: rst_n clears parser, queue and back end at once; no clearing pass.
`timescale 1ns / 1ps
module ppm_stream_decoder_core
    import ppm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
    input logic      clk,
    input logic      rst_n,
    ppm_stream_if.sink   in_ch,
    ppm_stream_if.source out_ch
);
    logic     pj_valid, pj_ready, bj_valid, bj_ready;
    ppm_job_t pj, bj;

    ppm_parser #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_parser (
        .clk, .rst_n,
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_beat  (in_ch.payload),
        .job_valid(pj_valid),
        .job_ready(pj_ready),
        .job      (pj)
    );

    ppm_job_fifo #(.DEPTH(4)) u_fifo (
        .clk, .rst_n,
        .wr_valid(pj_valid), .wr_ready(pj_ready), .wr_data(pj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    ppm_scaler u_scaler (
        .clk, .rst_n,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_beat(out_ch.payload)
    );

endmodule
